@@ src/deq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// shared types for the bounded double-ended queue: word formats, command
// codes and the control and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int unsigned FIELD_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SIZE       = 3'd4,
        CMD_EMPTY      = 3'd5,
        CMD_FRONT      = 3'd6,
        CMD_BACK       = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t                           command;
        logic signed [FIELD_WIDTH-1:0]  push_value;
    } in_word_t;

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0]  result_value;
        logic                           was_empty;
    } out_word_t;

    typedef struct packed {
        logic load_in;
        logic write_mem;
        logic read_mem;
        logic load_out_calc;
        logic load_out_mem;
        logic ins_front;
        logic ins_back;
        logic rem_front;
        logic rem_back;
    } ctl_t;

    typedef struct packed {
        cmd_t command;
        logic is_empty;
        logic is_full;
        logic out_full;
    } sts_t;

endpackage

@@ src/deq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// one-hot sequencer: takes a word, executes it, and for pops and peeks on a
// non-empty queue waits on the registered store read
// ----------------------------------------------------------------------------
module deq_ctrl
    import deq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_push;
    logic   is_query;

    assign is_push  = (sts.command == CMD_PUSH_FRONT) || (sts.command == CMD_PUSH_BACK);
    assign is_query = (sts.command == CMD_SIZE) || (sts.command == CMD_EMPTY);
    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_push)
                begin
                    if (!sts.is_full)
                    begin
                        ctl.write_mem = 1'b1;
                        ctl.ins_front = (sts.command == CMD_PUSH_FRONT);
                        ctl.ins_back  = (sts.command == CMD_PUSH_BACK);
                    end
                    state_next = S_IDLE;
                end
                else if (!sts.out_full)
                begin
                    if (is_query || sts.is_empty)
                    begin
                        ctl.load_out_calc = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        ctl.read_mem = 1'b1;
                        state_next   = S_READ;
                    end
                end
            end
            S_READ:
            begin
                ctl.load_out_mem = 1'b1;
                ctl.rem_front    = (sts.command == CMD_POP_FRONT);
                ctl.rem_back     = (sts.command == CMD_POP_BACK);
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/deq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// circular element store with head pointer and count, input word register
// and output word register
// ----------------------------------------------------------------------------
module deq_dp
    import deq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 1024,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  cmd_word,
    input  ctl_t      ctl,
    output sts_t      sts,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output out_word_t rsp_word
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = (DATA_WIDTH > FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [AW:0]   CAP_WIDE  = (AW + 1)'(CAPACITY);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];

    in_word_t              in_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    out_word_t             rsp_word_reg;
    out_word_t             rsp_word_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW:0]           tail_sum;
    logic [AW:0]           last_sum;
    logic [AW-1:0]         tail_slot;
    logic [AW-1:0]         last_slot;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [XW-1:0]         push_ext;
    logic [XW-1:0]         rd_ext;
    logic                  is_front;

    assign tail_sum  = (AW + 1)'(head_reg) + (AW + 1)'(count_reg);
    assign last_sum  = tail_sum - (AW + 1)'(1);
    assign tail_slot = (tail_sum >= CAP_WIDE) ? AW'(tail_sum - CAP_WIDE) : tail_sum[AW-1:0];
    assign last_slot = (last_sum >= CAP_WIDE) ? AW'(last_sum - CAP_WIDE) : last_sum[AW-1:0];
    assign head_dec  = (head_reg == '0) ? LAST_SLOT : head_reg - AW'(1);
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);

    assign is_front  = (in_reg.command == CMD_POP_FRONT) || (in_reg.command == CMD_FRONT);
    assign wr_addr   = ctl.ins_front ? head_dec : tail_slot;
    assign rd_addr   = is_front ? head_reg : last_slot;
    assign push_ext  = XW'(in_reg.push_value);
    assign rd_ext    = XW'($signed(rd_data_reg));

    assign sts.command  = in_reg.command;
    assign sts.is_empty = (count_reg == '0);
    assign sts.is_full  = (count_reg == CW'(CAPACITY));
    assign sts.out_full = rsp_valid_reg;

    // store port
    always_ff @(posedge clk)
    begin
        if (ctl.write_mem)
        begin
            mem[wr_addr] <= push_ext[DATA_WIDTH-1:0];
        end
        if (ctl.read_mem)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            in_reg <= cmd_word;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctl.ins_front)
        begin
            head_next  = head_dec;
            count_next = count_reg + CW'(1);
        end
        else if (ctl.ins_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.rem_front)
        begin
            head_next  = head_inc;
            count_next = count_reg - CW'(1);
        end
        else if (ctl.rem_back)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        if (ctl.load_out_mem)
        begin
            rsp_valid_next             = 1'b1;
            rsp_word_next.result_value = rd_ext[FIELD_WIDTH-1:0];
            rsp_word_next.was_empty    = 1'b0;
        end
        else if (ctl.load_out_calc)
        begin
            rsp_valid_next = 1'b1;
            case (in_reg.command)
                CMD_SIZE:
                begin
                    rsp_word_next.result_value = FIELD_WIDTH'(count_reg);
                    rsp_word_next.was_empty    = 1'b0;
                end
                CMD_EMPTY:
                begin
                    rsp_word_next.result_value = FIELD_WIDTH'(sts.is_empty);
                    rsp_word_next.was_empty    = 1'b0;
                end
                default:
                begin
                    rsp_word_next.result_value = '1;
                    rsp_word_next.was_empty    = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

endmodule

@@ src/double_ended_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded double-ended queue over a circular store of CAPACITY entries
//
// cmd channel: cmd_valid / cmd_stall / cmd_word carries a command and a push
// value. rsp channel: rsp_valid / rsp_stall / rsp_word returns one word for
// every command but the pushes; pushes return nothing and a push onto a full
// queue is dropped. pops and peeks on an empty queue return -1 with was_empty.
// one command is in work at a time. a push writes the store in the execute
// state; size and empty load the output register there; pops and peeks on a
// non-empty queue add a state for the registered read of the store port.
// a new word is accepted in the cycle after a command finishes.
// the result sits in an output register, so the next command is taken while
// the receiver stalls; a command that needs that register waits until it
// drains. reset empties the queue at once; the store needs no clearing.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 1024,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  in_word_t  cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output out_word_t rsp_word
);

    ctl_t ctl;
    sts_t sts;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    deq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctl       (ctl),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_word  (rsp_word)
    );

    a_no_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(sts.is_full && sts.is_empty))
        else $error("queue reports full and empty together");

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.write_mem |-> !sts.is_full)
        else $error("store write while full");

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_out_calc || ctl.load_out_mem) |-> !sts.out_full)
        else $error("output register overwritten");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("second word accepted while first in work");

endmodule

@@ tb/deque_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// watches the cmd and rsp channels of the double-ended queue, keeps its own
// copy of the queue contents, works out the word each accepted command should
// return and compares every accepted rsp word against the oldest one waiting
// ----------------------------------------------------------------------------
module deque_checker
    import deq_pkg::*;
#(
    parameter int unsigned CAPACITY   = 1024,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  in_word_t  cmd_word,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  out_word_t rsp_word,
    output int        mismatch_count,
    output int        pending_count
);

    localparam int unsigned EXP_DEPTH = 64;

    logic [DATA_WIDTH-1:0] deque_store [CAPACITY];
    int unsigned           deque_head;
    int unsigned           deque_count;
    out_word_t             expected_words [EXP_DEPTH];
    int unsigned           exp_wr;
    int unsigned           exp_rd;
    int                    fail_total;

    task automatic note_mismatch(input string what, input out_word_t want, input out_word_t got);
        if (fail_total < 10)
            $display("%0t ns: %s: expected value %h empty %b, got value %h empty %b",
                     $time, what, want.result_value, want.was_empty,
                     got.result_value, got.was_empty);
        fail_total++;
    endtask

    task automatic add_expected(input out_word_t r);
        expected_words[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // updates the queue copy and queues the word the command should return
    task automatic apply_command(input in_word_t w);
        logic [DATA_WIDTH-1:0] elem;
        int unsigned           slot;
        out_word_t             r;
        elem = DATA_WIDTH'(w.push_value);
        r    = '0;
        case (w.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (deque_count < CAPACITY)
                begin
                    if (w.command == CMD_PUSH_FRONT)
                    begin
                        deque_head = (deque_head == 0) ? CAPACITY - 1 : deque_head - 1;
                        slot       = deque_head;
                    end
                    else
                    begin
                        slot = (deque_head + deque_count) % CAPACITY;
                    end
                    deque_store[slot] = elem;
                    deque_count++;
                end
            end
            CMD_SIZE:
            begin
                r.result_value = FIELD_WIDTH'(deque_count);
                add_expected(r);
            end
            CMD_EMPTY:
            begin
                r.result_value = (deque_count == 0) ? 1 : 0;
                add_expected(r);
            end
            default:
            begin
                if (deque_count == 0)
                begin
                    r.result_value = '1;
                    r.was_empty    = 1'b1;
                end
                else
                begin
                    if (w.command == CMD_POP_FRONT || w.command == CMD_FRONT)
                        slot = deque_head;
                    else
                        slot = (deque_head + deque_count - 1) % CAPACITY;
                    r.result_value = FIELD_WIDTH'(signed'(deque_store[slot]));
                    if (w.command == CMD_POP_FRONT)
                    begin
                        deque_head = (deque_head + 1) % CAPACITY;
                        deque_count--;
                    end
                    else if (w.command == CMD_POP_BACK)
                    begin
                        deque_count--;
                    end
                end
                add_expected(r);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            deque_head  = 0;
            deque_count = 0;
            exp_wr      = 0;
            exp_rd      = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (exp_wr == exp_rd)
                begin
                    note_mismatch("unexpected word", '0, rsp_word);
                end
                else
                begin
                    want = expected_words[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (rsp_word.result_value !== want.result_value)
                        note_mismatch("result_value", want, rsp_word);
                    else if (rsp_word.was_empty !== want.was_empty)
                        note_mismatch("was_empty", want, rsp_word);
                end
            end
            if (cmd_valid && !cmd_stall)
                apply_command(cmd_word);
        end
        mismatch_count <= fail_total;
        pending_count  <= int'(exp_wr - exp_rd);
    end

endmodule

@@ tb/double_ended_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// drives commands into the double-ended queue: a directed opening over the
// empty queue, both ends, index wrap and extreme values, then random words
// that work near empty, fill the queue past full and take it back down,
// under changing idle patterns and one long receiver hold; the checker judges
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
    import deq_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    in_word_t  cmd_word;
    logic      rsp_valid;
    logic      rsp_stall;
    out_word_t rsp_word;

    int        mismatch_count;
    int        pending_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_go;
    logic      recv_hold;

    double_ended_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    deque_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_word       (cmd_word),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_word       (rsp_word),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);

    // long receiver hold so the output register fills and the cmd side stalls
    initial
    begin : receiver_hold
        recv_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        recv_hold <= 1'b1;
        repeat (400) @(posedge clk);
        recv_hold <= 1'b0;
    end

    initial
    begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end

    // called at a rising edge; returns at the edge that takes the word
    task automatic send_word(input cmd_t c, input logic [FIELD_WIDTH-1:0] v);
        bit taken;
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= '{command: c, push_value: v};
        do
        begin
            @(negedge clk);
            taken = !cmd_stall;
            @(posedge clk);
        end
        while (!taken);
    endtask

    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_t pick_command(input int unsigned push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return cmd_t'($urandom_range(CMD_BACK, CMD_POP_FRONT));
    endfunction

    task automatic run_random(input int count, input int unsigned push_pct);
        for (int i = 0; i < count; i++)
            send_word(pick_command(push_pct), pick_value());
    endtask

    initial
    begin : stimulus
        int drain;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd_word      = '0;
        hold_go       = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 49;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue
        send_word(CMD_SIZE, '0);
        send_word(CMD_EMPTY, '1);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_FRONT, '1);
        send_word(CMD_BACK, '0);
        // head wraps below slot zero, extreme values at both ends
        send_word(CMD_PUSH_FRONT, 32'h7fff_ffff);
        send_word(CMD_PUSH_BACK, 32'h8000_0000);
        send_word(CMD_PUSH_FRONT, '1);
        send_word(CMD_PUSH_BACK, '0);
        send_word(CMD_FRONT, '0);
        send_word(CMD_BACK, '0);
        send_word(CMD_SIZE, '0);
        send_word(CMD_EMPTY, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_POP_BACK, '0);
        send_word(CMD_POP_FRONT, '0);
        send_word(CMD_EMPTY, '0);
        send_word(CMD_SIZE, '0);

        // mostly around empty
        run_random(300, 50);

        // fill past full, with the long hold in the middle
        send_idle_pct = 49;
        recv_idle_pct <= 21;
        run_random(500, 96);
        hold_go <= 1'b1;
        run_random(650, 96);

        // drain without idling
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random(350, 10);

        cmd_valid <= 1'b0;
        repeat (2) @(posedge clk);
        drain = 0;
        while (pending_count != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/deq_pkg.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue_top.sv
tb/deque_checker.sv
tb/double_ended_queue_top_tb.sv
